// ===== hdl/cdds_pkg.sv =====
package cdds_pkg;

  localparam int SET_DEPTH = 64;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int DAY_W     = 5;
  localparam int MON_W     = 4;
  localparam int TOTAL_W   = 7;
  localparam logic [MON_W-1:0] MONTH_FIRST = MON_W'(1);
  localparam logic [MON_W-1:0] MONTH_LAST  = MON_W'(12);

  // Days in each month code, February always 28; codes that are no month give zero.
  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  typedef enum logic {
    FUNC_ADD    = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_DUP     = 3'd1,
    ST_INVALID = 3'd2,
    ST_FULL    = 3'd3,
    ST_REMOVED = 3'd4,
    ST_EMPTY   = 3'd5
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [TOTAL_W-1:0] entry_total;
  } res_t;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [MON_W-1:0] month;
  } entry_t;

  // Search token that walks down the chain one cell per cycle.
  typedef struct packed {
    logic   live;
    logic   hit;
    entry_t key;
  } token_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  function automatic logic date_ok(input logic [DAY_W-1:0] day,
                                   input logic [MON_W-1:0] month);
    logic month_ok;
    month_ok = (month >= MONTH_FIRST) && (month <= MONTH_LAST);
    return month_ok && (day != '0) && (day <= MONTH_LEN[month]);
  endfunction

endpackage

// ===== hdl/cdds_cell.sv =====
module cdds_cell (
  input  logic            clk,
  input  logic            rst,
  input  cdds_pkg::shift_t shift,
  input  logic            occupied,
  input  cdds_pkg::entry_t prev_entry,
  input  cdds_pkg::entry_t next_entry,
  output cdds_pkg::entry_t entry,
  input  cdds_pkg::token_t tok_in,
  output cdds_pkg::token_t tok_out
);

  // A push moves every entry one place toward the tail, a pop one place toward the head.
  always_ff @(posedge clk) begin
    if (shift.push) begin
      entry <= prev_entry;
    end else if (shift.pop) begin
      entry <= next_entry;
    end
  end

  // Only the live flag needs a reset; key and hit are ignored while the token is dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out.live <= tok_in.live;
    end
    tok_out.key <= tok_in.key;
    tok_out.hit <= tok_in.hit | (tok_in.live & occupied & (tok_in.key == entry));
  end

endmodule

// ===== hdl/calendar_date_dedup_set_top.sv =====
// Insertion-ordered set of calendar dates (day, month), up to SET_DEPTH entries.
// Requests arrive on req_valid/req_stall/req_item: an add carries a day and a month,
// a remove drops the most recently added entry. Each request yields exactly one
// result on res_valid/res_stall/res_item with a status and the entry count after it.
// One request is in work at a time; req_stall stays high until its result has been
// loaded into the output register.
// A remove or an invalid date moves from IDLE straight to FINISH, where its result is
// loaded into the output register. A valid add sends a search token down the row of
// SET_DEPTH cells, one cell per cycle, and waits in SCAN until the token leaves the
// tail cell; the verdict is then set in FINISH and the result is loaded from there.
// A new request is accepted only once the previous one has left FINISH.
// The output register holds a finished result while the receiver stalls, and a new
// request is taken meanwhile; its own result waits until the register is free.
// Reset empties the set and clears all handshake state; stored dates are not
// cleared, since cells at or beyond the count are never compared.
module calendar_date_dedup_set_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cdds_pkg::req_t req_item,
  output logic           res_valid,
  input  logic           res_stall,
  output cdds_pkg::res_t res_item
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t                     state;
  cdds_pkg::entry_t           key;
  cdds_pkg::status_t          verdict;
  logic [cdds_pkg::CNT_W-1:0] count;
  logic [cdds_pkg::CNT_W-1:0] count_next;

  cdds_pkg::entry_t entries [cdds_pkg::SET_DEPTH];
  cdds_pkg::token_t toks    [cdds_pkg::SET_DEPTH+1];
  cdds_pkg::shift_t shift;

  logic accept;
  logic fire;
  logic req_date_ok;

  assign req_stall   = (state != IDLE);
  assign accept      = req_valid && !req_stall;
  assign req_date_ok = cdds_pkg::date_ok(req_item.day, req_item.month);

  // The result is loaded once the output register is empty or being drained.
  assign fire = (state == FINISH) && (!res_valid || !res_stall);

  assign shift.push = fire && (verdict == cdds_pkg::ST_ADDED);
  assign shift.pop  = fire && (verdict == cdds_pkg::ST_REMOVED);

  always_comb begin
    count_next = count;
    if (verdict == cdds_pkg::ST_ADDED) begin
      count_next = count + cdds_pkg::CNT_W'(1);
    end else if (verdict == cdds_pkg::ST_REMOVED) begin
      count_next = count - cdds_pkg::CNT_W'(1);
    end
  end

  // A valid add launches its search token into the head cell as it is accepted.
  assign toks[0].live = accept && (req_item.func == cdds_pkg::FUNC_ADD) && req_date_ok;
  assign toks[0].hit  = 1'b0;
  assign toks[0].key  = '{day: req_item.day, month: req_item.month};

  // Cell 0 holds the most recent entry; cells below the count are occupied.
  for (genvar i = 0; i < cdds_pkg::SET_DEPTH; i++) begin : g_cell
    cdds_pkg::entry_t next_e;
    if (i == cdds_pkg::SET_DEPTH - 1) begin : g_tail
      assign next_e = entries[i];
    end else begin : g_mid
      assign next_e = entries[i+1];
    end
    if (i == 0) begin : g_head
      cdds_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (shift),
        .occupied   (count > cdds_pkg::CNT_W'(i)),
        .prev_entry (key),
        .next_entry (next_e),
        .entry      (entries[i]),
        .tok_in     (toks[i]),
        .tok_out    (toks[i+1])
      );
    end else begin : g_body
      cdds_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (shift),
        .occupied   (count > cdds_pkg::CNT_W'(i)),
        .prev_entry (entries[i-1]),
        .next_entry (next_e),
        .entry      (entries[i]),
        .tok_in     (toks[i]),
        .tok_out    (toks[i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (fire) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            key <= '{day: req_item.day, month: req_item.month};
            if (req_item.func == cdds_pkg::FUNC_REMOVE) begin
              verdict <= (count != '0) ? cdds_pkg::ST_REMOVED : cdds_pkg::ST_EMPTY;
              state   <= FINISH;
            end else if (!req_date_ok) begin
              verdict <= cdds_pkg::ST_INVALID;
              state   <= FINISH;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (toks[cdds_pkg::SET_DEPTH].live) begin
            if (toks[cdds_pkg::SET_DEPTH].hit) begin
              verdict <= cdds_pkg::ST_DUP;
            end else if (count == cdds_pkg::CNT_W'(cdds_pkg::SET_DEPTH)) begin
              verdict <= cdds_pkg::ST_FULL;
            end else begin
              verdict <= cdds_pkg::ST_ADDED;
            end
            state <= FINISH;
          end
        end
        FINISH: begin
          if (fire) begin
            count                <= count_next;
            res_item.status      <= verdict;
            res_item.entry_total <= cdds_pkg::TOTAL_W'(count_next);
            state                <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cdds_pkg::CNT_W'(cdds_pkg::SET_DEPTH))
    else $error("entry count beyond set depth");

  a_count_moves_on_fire: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(fire) || $past(rst)))
    else $error("entry count changed without a result");

  a_token_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    toks[cdds_pkg::SET_DEPTH].live |-> (state == SCAN))
    else $error("search token left the chain outside a scan");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == FINISH))
    else $error("result appeared without a finished request");

endmodule
